// ===== rtl/cmp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the chained low-rank projection block.
// Used by cmp_down_cell, cmp_up_cell and chained_matvec_projection_top.
package cmp_pkg;

    localparam int ROW_WIDTH    = 4;
    localparam int RANK         = 4;
    localparam int QUERY_WIDTH  = 4;
    localparam int HEADS        = 2;

    localparam int ACT_FIELDS   = 4;
    localparam int QUERY_FIELDS = 4;
    localparam int HEAD_FIELDS  = 2;

    localparam int DATA_W    = 16;
    localparam int FRAC      = 14;
    localparam int SEL_W     = 2;
    localparam int IDX_W     = 4;
    localparam int CELL_ID_W = 4;

    localparam int DN_SUM_W = 2 * DATA_W + $clog2(ROW_WIDTH);
    localparam int MID_W    = DN_SUM_W - FRAC;
    localparam int UP_SUM_W = MID_W + DATA_W + $clog2(RANK);
    localparam int Q_OUT_W  = 24;
    localparam int H_OUT_W  = 20;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_TOKEN = 1'b1;

    localparam logic [SEL_W-1:0] SEL_DOWN = 2'd0;
    localparam logic [SEL_W-1:0] SEL_UP   = 2'd1;
    localparam logic [SEL_W-1:0] SEL_HEAD = 2'd2;

    typedef struct packed {
        logic              action;
        logic [SEL_W-1:0]  sel;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] val;
    } t_load;

    typedef struct packed {
        logic                                valid;
        t_load                               ld;
        logic [ROW_WIDTH-1:0][DATA_W-1:0]    act;
        logic [RANK-1:0][DN_SUM_W-1:0]       dsum;
        logic [HEADS-1:0][DN_SUM_W-1:0]      hsum;
    } t_dn_stage;

    typedef struct packed {
        logic                                valid;
        t_load                               ld;
        logic [RANK-1:0][MID_W-1:0]          mid;
        logic [QUERY_WIDTH-1:0][UP_SUM_W-1:0] qsum;
        logic [HEADS-1:0][MID_W-1:0]         head;
    } t_up_stage;

endpackage

// ===== rtl/cmp_down_cell.sv =====
`timescale 1ns / 1ps
// One cell of the down/head chain: holds one row of the down and head matrices.
// Depends on cmp_pkg.
module cmp_down_cell (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic [cmp_pkg::CELL_ID_W-1:0]     i_id,
    input  cmp_pkg::t_dn_stage                i_d,
    output cmp_pkg::t_dn_stage                o_d
);

    logic signed [cmp_pkg::DATA_W-1:0]   r_dw [cmp_pkg::RANK];
    logic signed [cmp_pkg::DATA_W-1:0]   r_hw [cmp_pkg::HEADS];
    logic signed [cmp_pkg::DATA_W-1:0]   a;
    logic signed [2*cmp_pkg::DATA_W-1:0] prod_d [cmp_pkg::RANK];
    logic signed [2*cmp_pkg::DATA_W-1:0] prod_h [cmp_pkg::HEADS];
    logic                                tok;
    logic                                ld;
    cmp_pkg::t_dn_stage                  n_d;
    cmp_pkg::t_dn_stage                  r_d;

    assign tok = i_d.valid && (i_d.ld.action == cmp_pkg::ACT_TOKEN);
    assign ld  = i_en && i_d.valid && (i_d.ld.action == cmp_pkg::ACT_LOAD);

    always_comb begin
        a = '0;
        for (int k = 0; k < cmp_pkg::ROW_WIDTH; k++) begin
            if (k == int'(i_id)) begin
                a = i_d.act[k];
            end
        end
        n_d = i_d;
        for (int j = 0; j < cmp_pkg::RANK; j++) begin
            prod_d[j] = a * r_dw[j];
            if (tok) begin
                n_d.dsum[j] = cmp_pkg::DN_SUM_W'($signed(i_d.dsum[j])
                              + cmp_pkg::DN_SUM_W'(prod_d[j]));
            end
        end
        for (int j = 0; j < cmp_pkg::HEADS; j++) begin
            prod_h[j] = a * r_hw[j];
            if (tok) begin
                n_d.hsum[j] = cmp_pkg::DN_SUM_W'($signed(i_d.hsum[j])
                              + cmp_pkg::DN_SUM_W'(prod_h[j]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < cmp_pkg::RANK; j++) begin
                r_dw[j] <= '0;
            end
            for (int j = 0; j < cmp_pkg::HEADS; j++) begin
                r_hw[j] <= '0;
            end
        end else begin
            for (int j = 0; j < cmp_pkg::RANK; j++) begin
                if (ld && i_d.ld.sel == cmp_pkg::SEL_DOWN
                    && int'(i_d.ld.idx) == int'(i_id) * cmp_pkg::RANK + j) begin
                    r_dw[j] <= i_d.ld.val;
                end
            end
            for (int j = 0; j < cmp_pkg::HEADS; j++) begin
                if (ld && i_d.ld.sel == cmp_pkg::SEL_HEAD
                    && int'(i_d.ld.idx) == int'(i_id) * cmp_pkg::HEADS + j) begin
                    r_hw[j] <= i_d.ld.val;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.valid <= 1'b0;
        end else if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

// ===== rtl/cmp_up_cell.sv =====
`timescale 1ns / 1ps
// One cell of the up-projection chain: holds one row of the up matrix.
// Depends on cmp_pkg.
module cmp_up_cell (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic [cmp_pkg::CELL_ID_W-1:0]     i_id,
    input  cmp_pkg::t_up_stage                i_d,
    output cmp_pkg::t_up_stage                o_d
);

    logic signed [cmp_pkg::DATA_W-1:0]                r_uw [cmp_pkg::QUERY_WIDTH];
    logic signed [cmp_pkg::MID_W-1:0]                 m;
    logic signed [cmp_pkg::MID_W+cmp_pkg::DATA_W-1:0] prod [cmp_pkg::QUERY_WIDTH];
    logic                                             tok;
    logic                                             ld;
    cmp_pkg::t_up_stage                               n_d;
    cmp_pkg::t_up_stage                               r_d;

    assign tok = i_d.valid && (i_d.ld.action == cmp_pkg::ACT_TOKEN);
    assign ld  = i_en && i_d.valid && (i_d.ld.action == cmp_pkg::ACT_LOAD)
                 && (i_d.ld.sel == cmp_pkg::SEL_UP);

    always_comb begin
        m = '0;
        for (int k = 0; k < cmp_pkg::RANK; k++) begin
            if (k == int'(i_id)) begin
                m = i_d.mid[k];
            end
        end
        n_d = i_d;
        for (int j = 0; j < cmp_pkg::QUERY_WIDTH; j++) begin
            prod[j] = m * r_uw[j];
            if (tok) begin
                n_d.qsum[j] = cmp_pkg::UP_SUM_W'($signed(i_d.qsum[j])
                              + cmp_pkg::UP_SUM_W'(prod[j]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < cmp_pkg::QUERY_WIDTH; j++) begin
                r_uw[j] <= '0;
            end
        end else begin
            for (int j = 0; j < cmp_pkg::QUERY_WIDTH; j++) begin
                if (ld && int'(i_d.ld.idx) == int'(i_id) * cmp_pkg::QUERY_WIDTH + j) begin
                    r_uw[j] <= i_d.ld.val;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.valid <= 1'b0;
        end else if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

// ===== rtl/chained_matvec_projection_top.sv =====
`timescale 1ns / 1ps
// Chained low-rank projection: down/head cell chain, up cell chain, output register.
// Path: each input transfer is registered in every down cell, then every up cell, then the output register, to o_valid.
// Throughput: one item per cycle while o_stall is low; loads travel the chain in order with tokens.
// The whole chain holds while a result waits and the output is stalled.
// Synchronous active-low reset clears all weights and valid flags. Depends on cmp_pkg.
module chained_matvec_projection_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic                               i_action,
    input  logic [1:0]                         i_matrix_select,
    input  logic [3:0]                         i_weight_index,
    input  logic signed [15:0]                 i_weight_value,
    input  logic signed [15:0]                 i_act_0,
    input  logic signed [15:0]                 i_act_1,
    input  logic signed [15:0]                 i_act_2,
    input  logic signed [15:0]                 i_act_3,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [23:0]                 o_query_0,
    output logic signed [23:0]                 o_query_1,
    output logic signed [23:0]                 o_query_2,
    output logic signed [23:0]                 o_query_3,
    output logic signed [19:0]                 o_head_weight_0,
    output logic signed [19:0]                 o_head_weight_1
);

    localparam int NDN = cmp_pkg::ROW_WIDTH;
    localparam int NUP = cmp_pkg::RANK;

    logic                             en;
    logic [cmp_pkg::DATA_W-1:0]       act_in [cmp_pkg::ACT_FIELDS];
    cmp_pkg::t_dn_stage               dn_chain [NDN+1];
    cmp_pkg::t_up_stage               up_chain [NUP+1];
    cmp_pkg::t_up_stage               up_last;
    logic                             r_out_valid;
    logic signed [cmp_pkg::Q_OUT_W-1:0] r_query [cmp_pkg::QUERY_FIELDS];
    logic signed [cmp_pkg::H_OUT_W-1:0] r_head  [cmp_pkg::HEAD_FIELDS];
    logic signed [cmp_pkg::Q_OUT_W-1:0] n_query [cmp_pkg::QUERY_FIELDS];
    logic signed [cmp_pkg::H_OUT_W-1:0] n_head  [cmp_pkg::HEAD_FIELDS];

    assign o_stall = r_out_valid && i_stall;
    assign en      = !o_stall;

    assign act_in[0] = i_act_0;
    assign act_in[1] = i_act_1;
    assign act_in[2] = i_act_2;
    assign act_in[3] = i_act_3;

    assign dn_chain[0].valid     = i_valid;
    assign dn_chain[0].ld.action = i_action;
    assign dn_chain[0].ld.sel    = i_matrix_select;
    assign dn_chain[0].ld.idx    = i_weight_index;
    assign dn_chain[0].ld.val    = i_weight_value;
    assign dn_chain[0].dsum      = '0;
    assign dn_chain[0].hsum      = '0;

    for (genvar k = 0; k < NDN; k++) begin : g_act
        if (k < cmp_pkg::ACT_FIELDS) begin : g_in
            assign dn_chain[0].act[k] = act_in[k];
        end else begin : g_zero
            assign dn_chain[0].act[k] = '0;
        end
    end

    for (genvar g = 0; g < NDN; g++) begin : g_dn
        cmp_down_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_id    (cmp_pkg::CELL_ID_W'(g)),
            .i_d     (dn_chain[g]),
            .o_d     (dn_chain[g+1])
        );
    end

    always_comb begin
        up_chain[0].valid = dn_chain[NDN].valid;
        up_chain[0].ld    = dn_chain[NDN].ld;
        up_chain[0].qsum  = '0;
        for (int j = 0; j < cmp_pkg::RANK; j++) begin
            up_chain[0].mid[j] = cmp_pkg::MID_W'($signed(dn_chain[NDN].dsum[j])
                                 >>> cmp_pkg::FRAC);
        end
        for (int j = 0; j < cmp_pkg::HEADS; j++) begin
            up_chain[0].head[j] = cmp_pkg::MID_W'($signed(dn_chain[NDN].hsum[j])
                                  >>> cmp_pkg::FRAC);
        end
    end

    for (genvar g = 0; g < NUP; g++) begin : g_up
        cmp_up_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_id    (cmp_pkg::CELL_ID_W'(g)),
            .i_d     (up_chain[g]),
            .o_d     (up_chain[g+1])
        );
    end

    assign up_last = up_chain[NUP];

    for (genvar j = 0; j < cmp_pkg::QUERY_FIELDS; j++) begin : g_q
        if (j < cmp_pkg::QUERY_WIDTH) begin : g_on
            assign n_query[j] = cmp_pkg::Q_OUT_W'($signed(up_last.qsum[j]) >>> cmp_pkg::FRAC);
        end else begin : g_off
            assign n_query[j] = '0;
        end
    end

    for (genvar j = 0; j < cmp_pkg::HEAD_FIELDS; j++) begin : g_h
        if (j < cmp_pkg::HEADS) begin : g_on
            assign n_head[j] = cmp_pkg::H_OUT_W'($signed(up_last.head[j]));
        end else begin : g_off
            assign n_head[j] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= up_last.valid && (up_last.ld.action == cmp_pkg::ACT_TOKEN);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_query <= n_query;
            r_head  <= n_head;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_query_0       = r_query[0];
    assign o_query_1       = r_query[1];
    assign o_query_2       = r_query[2];
    assign o_query_3       = r_query[3];
    assign o_head_weight_0 = r_head[0];
    assign o_head_weight_1 = r_head[1];

endmodule
